// File: design/tasp_pkg.sv
// Shared types and constants for the three-axis slew-limited positioner.
// No dependencies; used by the channel interfaces and all design modules.

package tasp_pkg;

   // Axis and field geometry
   localparam int AXES     = 3;   // active axes
   localparam int AXES_MAX = 3;   // axes carried in the channel payloads
   localparam int LANE_W   = 16;  // width of one packed register lane
   localparam int ANGLE_W  = 16;  // saturation width of the joint output
   localparam int REG_W    = AXES_MAX * LANE_W;
   localparam int DIST_W   = LANE_W + 1;
   localparam int PROD_W   = 2 * LANE_W;

   // Arithmetic constants
   localparam int FACTOR_SHIFT = 14;
   localparam int ONE_Q15      = 32768;
   localparam int DIV_STEPS    = 15;
   localparam int CNT_W        = $clog2(DIV_STEPS);

   localparam logic [REG_W-1:0] FACTOR_RESET = {AXES_MAX{16'h4000}};

   // Item kinds
   localparam logic KIND_SET  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Configuration register indexes
   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_MIN_ANGLES   = 2'd0;
   localparam csr_idx_type CSR_MAX_ANGLES   = 2'd1;
   localparam csr_idx_type CSR_TURN_STEPS   = 2'd2;
   localparam csr_idx_type CSR_AXIS_FACTORS = 2'd3;

   // Status of one axis lane toward the merge stage
   typedef struct packed {
      logic              done;
      logic              clamped;
      logic              finished;
      logic [LANE_W-1:0] joint;
      logic [LANE_W-1:0] progress;
   } lane_stat_type;

endpackage

// File: design/tasp_channels.sv
// Valid/ready channel interfaces for the positioner request and response beats.
// Depends on tasp_pkg for field widths.

interface tasp_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic signed [tasp_pkg::LANE_W-1:0]  target_pitch;
   logic signed [tasp_pkg::LANE_W-1:0]  target_yaw;
   logic signed [tasp_pkg::LANE_W-1:0]  target_roll;

   modport source (output valid, kind, target_pitch, target_yaw, target_roll,
                   input ready);
   modport sink   (input valid, kind, target_pitch, target_yaw, target_roll,
                   output ready);
endinterface

interface tasp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                target_in_range;
   logic signed [tasp_pkg::LANE_W-1:0]  joint_pitch;
   logic signed [tasp_pkg::LANE_W-1:0]  joint_yaw;
   logic signed [tasp_pkg::LANE_W-1:0]  joint_roll;
   logic [tasp_pkg::LANE_W-1:0]         progress_pitch;
   logic [tasp_pkg::LANE_W-1:0]         progress_yaw;
   logic [tasp_pkg::LANE_W-1:0]         progress_roll;
   logic [tasp_pkg::AXES_MAX-1:0]       finished_mask;

   modport source (output valid, target_in_range, joint_pitch, joint_yaw, joint_roll,
                   progress_pitch, progress_yaw, progress_roll, finished_mask,
                   input ready);
   modport sink   (input valid, target_in_range, joint_pitch, joint_yaw, joint_roll,
                   progress_pitch, progress_yaw, progress_roll, finished_mask,
                   output ready);
endinterface

// File: design/tasp_lane.sv
// One axis lane: target clamp, slew step, joint scaling and a serial
// restoring divider for the progress fraction. Depends on tasp_pkg.

module tasp_lane (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  logic                              kind,
   input  logic signed [tasp_pkg::LANE_W-1:0] target,
   input  logic signed [tasp_pkg::LANE_W-1:0] min_angle,
   input  logic signed [tasp_pkg::LANE_W-1:0] max_angle,
   input  logic [tasp_pkg::LANE_W-1:0]        step,
   input  logic signed [tasp_pkg::LANE_W-1:0] factor,
   input  logic                              take,
   output tasp_pkg::lane_stat_type            stat
);

   typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_DIV, ST_DONE} state_type;

   localparam int LW = tasp_pkg::LANE_W;
   localparam int DW = tasp_pkg::DIST_W;
   localparam int PW = tasp_pkg::PROD_W;
   localparam logic signed [PW:0] ROUND_BIAS = (PW+1)'(1 << (tasp_pkg::FACTOR_SHIFT - 1));
   localparam logic signed [PW:0] SAT_HI = (PW+1)'((1 << (tasp_pkg::ANGLE_W - 1)) - 1);
   localparam logic signed [PW:0] SAT_LO = -SAT_HI - (PW+1)'(1);

   state_type                    state_ff, state_in;
   logic signed [LW-1:0]         ideal_ff, ideal_in;
   logic signed [LW-1:0]         current_ff, current_in;
   logic [DW-1:0]                start_ff, start_in;
   logic                         clamped_ff, clamped_in;
   logic signed [PW-1:0]         prod_ff, prod_in;
   logic [DW-1:0]                rem_ff, rem_in;
   logic [DW-1:0]                div_ff, div_in;
   logic [tasp_pkg::DIV_STEPS-1:0] quo_ff, quo_in;
   logic [tasp_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         zero_ff, zero_in;
   logic                         over_ff, over_in;

   logic signed [LW-1:0] clip_hi, clip_lo;
   logic signed [DW-1:0] set_diff, cur_diff, delta, step_s;
   logic [DW-1:0]        set_dist, cur_dist;
   logic [DW:0]          rem_x2;
   logic signed [PW:0]   rounded, shifted;
   logic signed [LW-1:0] joint_val;

   // Clamp: maximum first, then minimum
   assign clip_hi  = (target > max_angle) ? max_angle : target;
   assign clip_lo  = (clip_hi < min_angle) ? min_angle : clip_hi;
   assign set_diff = DW'(clip_lo) - DW'(current_ff);
   assign set_dist = set_diff[DW-1] ? DW'(-set_diff) : DW'(set_diff);

   // Distance still to go, also the slew delta before limiting
   assign cur_diff = DW'(ideal_ff) - DW'(current_ff);
   assign cur_dist = cur_diff[DW-1] ? DW'(-cur_diff) : DW'(cur_diff);
   assign step_s   = signed'({1'b0, step});
   always_comb begin
      delta = cur_diff;
      if (cur_diff > step_s) delta = step_s;
      if (cur_diff < -step_s) delta = -step_s;
   end

   // One restoring division step
   assign rem_x2 = {rem_ff, 1'b0};

   // Next-state logic
   always_comb begin
      state_in   = state_ff;
      ideal_in   = ideal_ff;
      current_in = current_ff;
      start_in   = start_ff;
      clamped_in = clamped_ff;
      prod_in    = prod_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      zero_in    = zero_ff;
      over_in    = over_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               if (kind == tasp_pkg::KIND_SET) begin
                  ideal_in   = clip_lo;
                  start_in   = set_dist;
                  clamped_in = (target > max_angle) || (clip_hi < min_angle);
               end else begin
                  current_in = current_ff + delta[LW-1:0];
                  clamped_in = 1'b0;
               end
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            prod_in  = current_ff * factor;
            rem_in   = cur_dist;
            div_in   = start_ff;
            zero_in  = (start_ff == '0);
            over_in  = (cur_dist >= start_ff);
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_x2 >= {1'b0, div_ff}) begin
               rem_in = DW'(rem_x2 - {1'b0, div_ff});
               quo_in = {quo_ff[tasp_pkg::DIV_STEPS-2:0], 1'b1};
            end else begin
               rem_in = rem_x2[DW-1:0];
               quo_in = {quo_ff[tasp_pkg::DIV_STEPS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == tasp_pkg::CNT_W'(tasp_pkg::DIV_STEPS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ideal_ff   <= '0;
         current_ff <= '0;
         start_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         ideal_ff   <= ideal_in;
         current_ff <= current_in;
         start_ff   <= start_in;
      end
      clamped_ff <= clamped_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      zero_ff    <= zero_in;
      over_ff    <= over_in;
   end

   // Joint: round half up, drop the Q2.14 fraction, saturate
   assign rounded = (PW+1)'(prod_ff) + ROUND_BIAS;
   assign shifted = rounded >>> tasp_pkg::FACTOR_SHIFT;
   always_comb begin
      if (shifted > SAT_HI)      joint_val = SAT_HI[LW-1:0];
      else if (shifted < SAT_LO) joint_val = SAT_LO[LW-1:0];
      else                       joint_val = shifted[LW-1:0];
   end

   // Lane status toward the merge stage
   always_comb begin
      stat.done     = (state_ff == ST_DONE);
      stat.clamped  = clamped_ff;
      stat.finished = (ideal_ff == current_ff);
      stat.joint    = joint_val;
      if (zero_ff)      stat.progress = LW'(tasp_pkg::ONE_Q15);
      else if (over_ff) stat.progress = '0;
      else              stat.progress = LW'(tasp_pkg::ONE_Q15) - LW'(quo_ff);
   end

endmodule

// File: design/tasp_merge.sv
// Merge stage: waits for all lanes, combines their status into one response
// beat and holds it in the output register. Depends on tasp_pkg, tasp_rsp_if.

module tasp_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    kind,
   input  tasp_pkg::lane_stat_type stats [tasp_pkg::AXES_MAX],
   output logic                    take,
   tasp_rsp_if.source              rsp_chan
);

   localparam int LW = tasp_pkg::LANE_W;

   logic                          valid_ff, valid_in;
   logic                          in_range_ff;
   logic [LW-1:0]                 joint_ff    [tasp_pkg::AXES_MAX];
   logic [LW-1:0]                 progress_ff [tasp_pkg::AXES_MAX];
   logic [tasp_pkg::AXES_MAX-1:0] mask_ff;
   logic                          all_done;
   logic                          any_clamped;
   logic [tasp_pkg::AXES_MAX-1:0] mask_cmb;

   // Gather lane results
   always_comb begin
      all_done    = 1'b1;
      any_clamped = 1'b0;
      for (int i = 0; i < tasp_pkg::AXES_MAX; i++) begin
         all_done    = all_done & stats[i].done;
         any_clamped = any_clamped | stats[i].clamped;
         mask_cmb[i] = stats[i].finished;
      end
   end

   assign take = all_done && (!valid_ff || rsp_chan.ready);

   always_comb begin
      valid_in = valid_ff;
      if (take)                valid_in = 1'b1;
      else if (rsp_chan.ready) valid_in = 1'b0;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         in_range_ff <= (kind == tasp_pkg::KIND_SET) && !any_clamped;
         mask_ff     <= mask_cmb;
         for (int i = 0; i < tasp_pkg::AXES_MAX; i++) begin
            joint_ff[i]    <= stats[i].joint;
            progress_ff[i] <= stats[i].progress;
         end
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.target_in_range = in_range_ff;
   assign rsp_chan.joint_pitch     = joint_ff[0];
   assign rsp_chan.joint_yaw       = joint_ff[1];
   assign rsp_chan.joint_roll      = joint_ff[2];
   assign rsp_chan.progress_pitch  = progress_ff[0];
   assign rsp_chan.progress_yaw    = progress_ff[1];
   assign rsp_chan.progress_roll   = progress_ff[2];
   assign rsp_chan.finished_mask   = mask_ff;

endmodule

// File: design/three_axis_slew_limited_positioner_top.sv
// Each request runs through the prepare step and the 15-step serial divider in
// each axis lane, all lanes running side by side; a new request is taken only
// once the previous lane results are merged into the response register.
// The response register frees the request side: a new beat is taken while a
// finished one still waits. Reset (synchronous, active high) zeroes all angles
// and limits and sets each axis factor to 1.0. Depends on tasp_pkg, channels.

module three_axis_slew_limited_positioner_top (
   input  logic                               clock,
   input  logic                               reset,
   tasp_req_if.sink                           req_chan,
   tasp_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  tasp_pkg::csr_idx_type              csr_index,
   input  logic [tasp_pkg::REG_W-1:0]         csr_wdata
);

   localparam int LW = tasp_pkg::LANE_W;

   logic [tasp_pkg::REG_W-1:0] min_ff, max_ff, steps_ff, factors_ff;
   logic                       busy_ff, busy_in;
   logic                       kind_ff;
   logic                       accept;
   logic                       take;
   logic signed [LW-1:0]       targets [tasp_pkg::AXES_MAX];
   tasp_pkg::lane_stat_type    stats   [tasp_pkg::AXES_MAX];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= '0;
         max_ff     <= '0;
         steps_ff   <= '0;
         factors_ff <= tasp_pkg::FACTOR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            tasp_pkg::CSR_MIN_ANGLES:   min_ff     <= csr_wdata;
            tasp_pkg::CSR_MAX_ANGLES:   max_ff     <= csr_wdata;
            tasp_pkg::CSR_TURN_STEPS:   steps_ff   <= csr_wdata;
            tasp_pkg::CSR_AXIS_FACTORS: factors_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request handshake: one item in flight
   assign req_chan.ready = !busy_ff;
   assign accept         = req_chan.valid && !busy_ff;

   always_comb begin
      busy_in = busy_ff;
      if (accept)    busy_in = 1'b1;
      else if (take) busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      if (accept) kind_ff <= req_chan.kind;
   end

   assign targets[0] = req_chan.target_pitch;
   assign targets[1] = req_chan.target_yaw;
   assign targets[2] = req_chan.target_roll;

   // Axis lanes; unused axes report done with zero fields
   for (genvar i = 0; i < tasp_pkg::AXES_MAX; i++) begin : g_lane
      if (i < tasp_pkg::AXES) begin : g_on
         tasp_lane u_lane (
            .clock     (clock),
            .reset     (reset),
            .go        (accept),
            .kind      (req_chan.kind),
            .target    (targets[i]),
            .min_angle (min_ff[i*LW +: LW]),
            .max_angle (max_ff[i*LW +: LW]),
            .step      (steps_ff[i*LW +: LW]),
            .factor    (factors_ff[i*LW +: LW]),
            .take      (take),
            .stat      (stats[i])
         );
      end else begin : g_off
         assign stats[i] = '{done: 1'b1, clamped: 1'b0, finished: 1'b0,
                             joint: '0, progress: '0};
      end
   end

   tasp_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .kind     (kind_ff),
      .stats    (stats),
      .take     (take),
      .rsp_chan (rsp_chan)
   );

   // Checks
   a_take_needs_busy: assert property (@(posedge clock) disable iff (reset)
      take |-> busy_ff)
      else $error("result merged with no item in flight");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && !req_chan.ready)
      else $error("request side open while an item is in flight");

   a_finished_full_progress: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.finished_mask[0] |->
         rsp_chan.progress_pitch == LW'(tasp_pkg::ONE_Q15))
      else $error("finished pitch axis without full progress");

   a_take_loads_valid: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_chan.valid)
      else $error("merged result not presented");

endmodule

// File: tb/tasp_pointing_checker.sv
// Checker for the three-axis slew-limited positioner: mirrors the CSR writes,
// predicts one response per request beat and compares it field by field.
// Depends on tasp_pkg and the channel interfaces in tasp_channels.sv.

module tasp_pointing_checker
   import tasp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   tasp_req_if                  req_mon,
   tasp_rsp_if                  rsp_mon,
   input  logic                 csr_we,
   input  csr_idx_type          csr_index,
   input  logic [REG_W-1:0]     csr_wdata,
   output int                   beats_owed,
   output int                   fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                          in_range;
      logic [AXES_MAX-1:0][LANE_W-1:0] joint;
      logic [AXES_MAX-1:0][LANE_W-1:0] progress;
      logic [AXES_MAX-1:0]             mask;
   } pointing_result_t;

   // Mirrored registers
   logic [REG_W-1:0] lo_limits, hi_limits, step_limits, gains;

   // Mirrored axis state
   logic signed [LANE_W-1:0] goal_angle [AXES_MAX];
   logic signed [LANE_W-1:0] pos_angle  [AXES_MAX];
   logic [DIST_W-1:0]        span       [AXES_MAX];

   pointing_result_t pointing_q [$];

   string axis_name [AXES_MAX] = '{"pitch", "yaw", "roll"};

   function automatic logic signed [LANE_W-1:0] lane_of(logic [REG_W-1:0] reg_v, int axis);
      return reg_v[axis*LANE_W +: LANE_W];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // Advance the axis state by one request beat and work out its response
   task automatic advance_axes(input logic kind, input logic [AXES_MAX-1:0][LANE_W-1:0] tgt,
                               output pointing_result_t res);
      longint t, hi, lo, step, delta, d, s, q, prod, r;
      logic   clamped;
      clamped = 1'b0;
      if (kind == KIND_SET) begin
         // clamp to max first, then min, so min wins when the limits cross
         for (int i = 0; i < AXES; i++) begin
            t  = longint'($signed(tgt[i]));
            hi = longint'(lane_of(hi_limits, i));
            lo = longint'(lane_of(lo_limits, i));
            if (t > hi) begin
               t = hi;
               clamped = 1'b1;
            end
            if (t < lo) begin
               t = lo;
               clamped = 1'b1;
            end
            goal_angle[i] = t[LANE_W-1:0];
            d = t - longint'(pos_angle[i]);
            if (d < 0) d = -d;
            span[i] = d[DIST_W-1:0];
         end
      end else begin
         // slew each axis toward its goal by at most its step
         for (int i = 0; i < AXES; i++) begin
            step  = longint'({48'h0, step_limits[i*LANE_W +: LANE_W]});
            delta = longint'(goal_angle[i]) - longint'(pos_angle[i]);
            if (delta > step)  delta = step;
            if (delta < -step) delta = -step;
            t = longint'(pos_angle[i]) + delta;
            pos_angle[i] = t[LANE_W-1:0];
         end
      end

      res = '0;
      res.in_range = (kind == KIND_SET) && !clamped;
      for (int i = 0; i < AXES; i++) begin
         // Q9.7 times Q2.14, round half up, saturate
         prod = longint'(pos_angle[i]) * longint'(lane_of(gains, i));
         r    = (prod + (longint'(1) << (FACTOR_SHIFT - 1))) >>> FACTOR_SHIFT;
         if (r > 32767)       r = 32767;
         else if (r < -32768) r = -32768;
         res.joint[i] = r[LANE_W-1:0];
         // progress = 1 - remaining / starting distance
         d = longint'(goal_angle[i]) - longint'(pos_angle[i]);
         if (d < 0) d = -d;
         s = longint'({47'h0, span[i]});
         if (s == 0) begin
            q = 0;
         end else begin
            q = (d * ONE_Q15) / s;
            if (q > ONE_Q15) q = ONE_Q15;
         end
         t = ONE_Q15 - q;
         res.progress[i] = t[LANE_W-1:0];
         res.mask[i] = (goal_angle[i] == pos_angle[i]);
      end
   endtask

   always @(posedge clock) begin : watch
      pointing_result_t seen, want, fresh;
      if (reset) begin
         lo_limits   = '0;
         hi_limits   = '0;
         step_limits = '0;
         gains       = FACTOR_RESET;
         for (int i = 0; i < AXES_MAX; i++) begin
            goal_angle[i] = '0;
            pos_angle[i]  = '0;
            span[i]       = '0;
         end
         pointing_q.delete();
         beats_owed <= 0;
      end else begin
         // response beat against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.in_range = rsp_mon.target_in_range;
            seen.joint    = {rsp_mon.joint_roll, rsp_mon.joint_yaw, rsp_mon.joint_pitch};
            seen.progress = {rsp_mon.progress_roll, rsp_mon.progress_yaw,
                             rsp_mon.progress_pitch};
            seen.mask     = rsp_mon.finished_mask;
            if (pointing_q.size() == 0) begin
               report_mismatch("response beat with no request outstanding");
            end else begin
               want = pointing_q.pop_front();
               if (seen.in_range !== want.in_range)
                  report_mismatch($sformatf("target_in_range got %0b want %0b",
                                            seen.in_range, want.in_range));
               for (int i = 0; i < AXES_MAX; i++) begin
                  if (seen.joint[i] !== want.joint[i])
                     report_mismatch($sformatf("joint_%s got %0d want %0d", axis_name[i],
                                               $signed(seen.joint[i]), $signed(want.joint[i])));
                  if (seen.progress[i] !== want.progress[i])
                     report_mismatch($sformatf("progress_%s got %0d want %0d", axis_name[i],
                                               seen.progress[i], want.progress[i]));
               end
               if (seen.mask !== want.mask)
                  report_mismatch($sformatf("finished_mask got %b want %b",
                                            seen.mask, want.mask));
            end
         end

         // request beat: predict its response
         if (req_mon.valid && req_mon.ready) begin
            advance_axes(req_mon.kind,
                         {req_mon.target_roll, req_mon.target_yaw, req_mon.target_pitch},
                         fresh);
            pointing_q.push_back(fresh);
         end

         // register mirror
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_ANGLES:   lo_limits   = csr_wdata;
               CSR_MAX_ANGLES:   hi_limits   = csr_wdata;
               CSR_TURN_STEPS:   step_limits = csr_wdata;
               CSR_AXIS_FACTORS: gains       = csr_wdata;
               default: ;
            endcase
         end

         beats_owed <= pointing_q.size();
      end
   end

endmodule

// File: tb/three_axis_slew_limited_positioner_top_tb.sv
// Testbench top for the three-axis slew-limited positioner: clock, reset,
// directed and random request beats, CSR phases, watchdog and verdict.
// Depends on tasp_pkg, tasp_channels.sv and tasp_pointing_checker.

module three_axis_slew_limited_positioner_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tasp_pkg::*;

   localparam int STALL_LIMIT = 4000;  // cycles with no beat before giving up
   localparam int DRAIN       = 24;    // settle time after the last response
   localparam int RAND_ITEMS  = 1900;
   localparam int PHASES      = 6;

   logic             clock;
   logic             reset;
   logic             csr_we;
   csr_idx_type      csr_index;
   logic [REG_W-1:0] csr_wdata;
   int               beats_owed;
   int               fail_count;
   int               quiet_cycles;
   bit               steady;

   // stimulus copy of the limits, used to aim targets
   logic [REG_W-1:0] min_set, max_set;

   tasp_req_if req_if ();
   tasp_rsp_if rsp_if ();

   three_axis_slew_limited_positioner_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tasp_pointing_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .beats_owed (beats_owed),
      .fail_count (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side backpressure
   always @(posedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(99) >= 35);
   end

   // watchdog on beat activity
   always @(posedge clock) begin
      if (reset || csr_we || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // write all four registers on back-to-back edges
   task automatic load_settings(input logic [REG_W-1:0] lo, hi, steps, factors);
      min_set = lo;
      max_set = hi;
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_ANGLES;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_MAX_ANGLES;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_TURN_STEPS;
      csr_wdata <= steps;
      @(posedge clock);
      csr_index <= CSR_AXIS_FACTORS;
      csr_wdata <= factors;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // hold off until every response is back, then let the pipe settle
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (beats_owed != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // present one request beat and wait for it to be taken
   task automatic send_beat(input logic k, input logic [LANE_W-1:0] p, y, r);
      while (!steady && $urandom_range(99) < 35) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.kind         <= k;
      req_if.target_pitch <= p;
      req_if.target_yaw   <= y;
      req_if.target_roll  <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // mostly inside the axis limits, sometimes at or past the edges
   function automatic logic [LANE_W-1:0] pick_angle(int axis);
      int lo, hi;
      lo = int'($signed(min_set[axis*LANE_W +: LANE_W]));
      hi = int'($signed(max_set[axis*LANE_W +: LANE_W]));
      if ($urandom_range(99) < 75 && lo <= hi)
         return LANE_W'(lo + int'($urandom_range(hi - lo)));
      case ($urandom_range(5))
         0:       return LANE_W'(lo);
         1:       return LANE_W'(hi);
         2:       return 16'h7FFF;
         3:       return 16'h8000;
         default: return LANE_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      logic [LANE_W-1:0] a, b, tmp;
      logic [REG_W-1:0]  lo_v, hi_v, step_v, gain_v;
      int                sent, ticks;

      req_if.valid        = 1'b0;
      req_if.kind         = KIND_SET;
      req_if.target_pitch = '0;
      req_if.target_yaw   = '0;
      req_if.target_roll  = '0;
      csr_we              = 1'b0;
      csr_index           = CSR_MIN_ANGLES;
      csr_wdata           = '0;
      reset               = 1'b1;
      steady              = 1'b0;
      min_set             = '0;
      max_set             = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset limits are all zero: every target clamps to zero, zero step never moves
      send_beat(KIND_SET, 16'h7FFF, 16'h8000, 16'h0000);
      send_beat(KIND_SET, 16'h0000, 16'h0000, 16'h0000);
      send_beat(KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      wait_drained();

      // full range; steps pitch max / yaw 1 / roll 0; gains +max, -2.0, 1.0
      load_settings({3{16'h8000}}, {3{16'h7FFF}}, {16'h0000, 16'h0001, 16'hFFFF},
                    {16'h4000, 16'h8000, 16'h7FFF});
      send_beat(KIND_SET, 16'h7FFF, 16'h8000, 16'h0064);
      send_beat(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
      send_beat(KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(KIND_SET, 16'h8000, 16'h7FFF, 16'hFFFF);
      send_beat(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
      send_beat(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
      send_beat(KIND_SET, 16'h0000, 16'h0000, 16'h0000);
      send_beat(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
      wait_drained();

      // crossed limits: minimum wins and the target reports out of range
      load_settings({3{16'h0100}}, {3{16'hFF00}}, {3{16'h0080}}, {3{16'h8000}});
      send_beat(KIND_SET, 16'h0000, 16'h0000, 16'h0000);
      send_beat(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
      send_beat(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
      send_beat(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
      send_beat(KIND_SET, 16'h7FFF, 16'h8000, 16'h1234);
      send_beat(KIND_TICK, 16'h0000, 16'h0000, 16'h0000);

      // random phases, each with fresh register settings
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         for (int i = 0; i < AXES_MAX; i++) begin
            a = LANE_W'($urandom);
            b = LANE_W'($urandom);
            case ($urandom_range(9))
               0: begin
                  a = 16'h8000;
                  b = 16'h7FFF;
               end
               1: ;  // unsorted, may cross
               default: begin
                  if ($signed(a) > $signed(b)) begin
                     tmp = a;
                     a   = b;
                     b   = tmp;
                  end
               end
            endcase
            lo_v[i*LANE_W +: LANE_W] = a;
            hi_v[i*LANE_W +: LANE_W] = b;
            case ($urandom_range(7))
               0:       step_v[i*LANE_W +: LANE_W] = 16'h0000;
               1:       step_v[i*LANE_W +: LANE_W] = 16'hFFFF;
               2:       step_v[i*LANE_W +: LANE_W] = LANE_W'($urandom);
               default: step_v[i*LANE_W +: LANE_W] = LANE_W'($urandom_range(600, 1));
            endcase
            case ($urandom_range(6))
               0:       gain_v[i*LANE_W +: LANE_W] = 16'h4000;
               1:       gain_v[i*LANE_W +: LANE_W] = 16'h7FFF;
               2:       gain_v[i*LANE_W +: LANE_W] = 16'h8000;
               3:       gain_v[i*LANE_W +: LANE_W] = 16'h0000;
               default: gain_v[i*LANE_W +: LANE_W] = LANE_W'($urandom);
            endcase
         end
         load_settings(lo_v, hi_v, step_v, gain_v);
         steady = (phase == 1);
         sent = 0;
         while (sent < RAND_ITEMS / PHASES) begin
            if ($urandom_range(99) < 85) begin
               // new target followed by a run of ticks
               send_beat(KIND_SET, pick_angle(0), pick_angle(1), pick_angle(2));
               sent++;
               ticks = ($urandom_range(4) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
               repeat (ticks) begin
                  send_beat(KIND_TICK, LANE_W'($urandom), LANE_W'($urandom),
                            LANE_W'($urandom));
                  sent++;
               end
            end else begin
               // noise beat, any kind and any payload
               send_beat(1'($urandom_range(1)), LANE_W'($urandom), LANE_W'($urandom),
                         LANE_W'($urandom));
               sent++;
            end
         end
      end
      steady = 1'b0;

      wait_drained();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
